>>> hw/rtl/deq_pkg.sv
// deq_pkg: shared types, codes and constants of the double-ended queue
// no dependencies; used by the interfaces and every module of the block
package deq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int OP_W       = 3;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // operation codes of an input item
  typedef enum logic [OP_W-1:0] {
    OP_LIST       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_PUSH_BACK  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // classified command kinds
  typedef enum logic [1:0] {
    CMD_LIST = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic                      at_front;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

endpackage

>>> hw/rtl/deq_if.sv
// deq_if: valid/ready channel interfaces for items and results
// depends on deq_pkg
interface deq_in_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::OP_W-1:0]          operation;
  logic signed [deq_pkg::DATA_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface deq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [deq_pkg::DATA_W-1:0] data;
  logic [deq_pkg::STATUS_W-1:0]      status;
  logic                              last;

  modport source (output valid, data, status, last, input ready);
  modport sink   (input valid, data, status, last, output ready);
endinterface

>>> hw/rtl/deq_front.sv
// deq_front: accepts input items and turns them into queue commands
// depends on deq_pkg and deq_if; unused operation codes are dropped here
module deq_front (
  deq_in_if.sink          in_ch,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output deq_pkg::cmd_t   cmd
);

  logic op_ok;

  always_comb begin
    op_ok        = 1'b1;
    cmd.kind     = deq_pkg::CMD_LIST;
    cmd.at_front = 1'b0;
    cmd.value    = in_ch.value;
    unique case (in_ch.operation)
      deq_pkg::OP_LIST: begin
        cmd.kind = deq_pkg::CMD_LIST;
      end
      deq_pkg::OP_PUSH_FRONT: begin
        cmd.kind     = deq_pkg::CMD_PUSH;
        cmd.at_front = 1'b1;
      end
      deq_pkg::OP_POP_FRONT: begin
        cmd.kind     = deq_pkg::CMD_POP;
        cmd.at_front = 1'b1;
      end
      deq_pkg::OP_PUSH_BACK: begin
        cmd.kind = deq_pkg::CMD_PUSH;
      end
      deq_pkg::OP_POP_BACK: begin
        cmd.kind = deq_pkg::CMD_POP;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // unused codes are taken and dropped, never queued
  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid && op_ok;

endmodule

>>> hw/rtl/deq_cmd_q.sv
// deq_cmd_q: short command queue between the front and back parts
// depends on deq_pkg
module deq_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  deq_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output deq_pkg::cmd_t  pop_cmd
);

  deq_pkg::cmd_t                 slot_r [deq_pkg::CMDQ_DEPTH];
  logic [deq_pkg::CMDQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [deq_pkg::CMDQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [deq_pkg::CMDQ_CW-1:0]   fill_r, fill_nxt;
  logic                          do_push, do_pop;

  function automatic logic [deq_pkg::CMDQ_AW-1:0] ptr_inc(
    input logic [deq_pkg::CMDQ_AW-1:0] p
  );
    if (p == deq_pkg::CMDQ_AW'(deq_pkg::CMDQ_DEPTH - 1)) begin
      return '0;
    end
    return p + deq_pkg::CMDQ_AW'(1);
  endfunction

  assign push_ready = (fill_r != deq_pkg::CMDQ_CW'(deq_pkg::CMDQ_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + deq_pkg::CMDQ_CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - deq_pkg::CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/deq_back.sv
// deq_back: ring store, front index and count; executes queued commands
// depends on deq_pkg and deq_if; drives the registered result channel
module deq_back #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  deq_pkg::cmd_t  cmd,
  deq_out_if.source      out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  logic [AW-1:0]                      front_r, front_nxt;
  logic [CW-1:0]                      count_r, count_nxt;
  logic [CW-1:0]                      walk_r, walk_nxt;
  logic                               is_list_r, is_list_nxt;
  logic                               last_pend_r, last_pend_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [deq_pkg::DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [deq_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic                               out_last_r, out_last_nxt;

  logic signed [deq_pkg::DATA_W-1:0]  mem [DEPTH];
  logic signed [deq_pkg::DATA_W-1:0]  rdata_r;
  logic                               we, re;
  logic [AW-1:0]                      waddr, raddr;

  logic                               out_free, cmd_fire, full, empty;
  logic [CW-1:0]                      count_m1;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [SW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_free  = !out_valid_r || out_ch.ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign count_m1  = count_r - CW'(1);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    walk_nxt       = walk_r;
    is_list_nxt    = is_list_r;
    last_pend_nxt  = last_pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = front_r;
    raddr          = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_fire) begin
          unique case (cmd.kind)
            deq_pkg::CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_status_nxt = deq_pkg::ST_OVERFLOW;
              end else begin
                out_status_nxt = deq_pkg::ST_OK;
                we             = 1'b1;
                count_nxt      = count_r + CW'(1);
                if (cmd.at_front) begin
                  front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
                  waddr     = front_nxt;
                end else begin
                  waddr = ring_add(front_r, count_r[AW-1:0]);
                end
              end
            end
            deq_pkg::CMD_POP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = deq_pkg::ST_UNDERFLOW;
                out_last_nxt   = 1'b1;
              end else begin
                re            = 1'b1;
                count_nxt     = count_m1;
                last_pend_nxt = 1'b1;
                is_list_nxt   = 1'b0;
                state_nxt     = S_WAIT;
                if (cmd.at_front) begin
                  raddr     = front_r;
                  front_nxt = ring_add(front_r, AW'(1));
                end else begin
                  raddr = ring_add(front_r, count_m1[AW-1:0]);
                end
              end
            end
            deq_pkg::CMD_LIST: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = deq_pkg::ST_UNDERFLOW;
                out_last_nxt   = 1'b1;
              end else begin
                re            = 1'b1;
                raddr         = front_r;
                walk_nxt      = CW'(1);
                last_pend_nxt = (count_r == CW'(1));
                is_list_nxt   = 1'b1;
                state_nxt     = S_WAIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_WAIT: begin
        // read data is back; the result register is known to be empty here
        out_valid_nxt  = 1'b1;
        out_data_nxt   = rdata_r;
        out_status_nxt = deq_pkg::ST_OK;
        out_last_nxt   = last_pend_r;
        state_nxt      = (is_list_r && !last_pend_r) ? S_LIST : S_IDLE;
      end
      S_LIST: begin
        if (out_free) begin
          re            = 1'b1;
          raddr         = ring_add(front_r, walk_r[AW-1:0]);
          last_pend_nxt = ((walk_r + CW'(1)) == count_r);
          walk_nxt      = walk_r + CW'(1);
          state_nxt     = S_WAIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    is_list_r    <= is_list_nxt;
    last_pend_r  <= last_pend_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // ring store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= cmd.value;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.status = out_status_r;
  assign out_ch.last   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_wait_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WAIT |-> !out_valid_r)
    else $error("read data returned while result register busy");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST || state_r == S_WAIT) |-> !empty || !is_list_r)
    else $error("list walk on an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && count_r != $past(count_r) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> state_r == S_IDLE && !re)
    else $error("store write outside a push");

endmodule

>>> hw/rtl/double_ended_queue_core.sv
// double_ended_queue_core: top level of the bounded double-ended queue
// depends on deq_pkg, deq_if, deq_front, deq_cmd_q and deq_back
//
// A bounded double-ended queue of signed 32-bit entries held in a ring store
// of DEPTH words. Each accepted item on in_ch carries an operation:
// list, push front, pop front, push back or pop back; codes 5 to 7 are taken
// and dropped with no result. Every other item gives one or more results on
// out_ch with last set on its final one: a push gives ok or overflow, a pop
// gives the removed entry or underflow, a list gives every entry from front to
// back (or a single underflow when empty). The front part classifies items
// into a two-entry command queue, so input keeps flowing while the back part
// works. In the back part a push completes in the idle state, while a pop and
// each entry of a list wait on the registered read port of the ring store.
// Results are held in an output register, so a stalled out_ch only stops the
// back part once that register is full. No clearing pass is needed after
// reset.
module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);

  // classified command, front part to queue
  logic           fq_valid, fq_ready;
  deq_pkg::cmd_t  fq_cmd;

  // queued command, queue to back part
  logic           qb_valid, qb_ready;
  deq_pkg::cmd_t  qb_cmd;

  // front part: takes every item, queues only the real operations
  deq_front u_front (
    .in_ch     (in_ch),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  // decoupling queue so either side can stall on its own
  deq_cmd_q u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // back part: ring store, indices and the result register
  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_ch    (out_ch)
  );

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for double_ended_queue_core
// depends on deq_pkg and deq_if from the rtl; predicts every result in-line and
// compares each out_ch transfer against the oldest pending expectation
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int DEPTH          = 16;
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int RESET_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 200;
  localparam int MAX_REPORTS    = 30;

  // operation codes the block takes and drops without a result
  localparam logic [deq_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [deq_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  // receiver stall behavior
  typedef enum int {
    RX_ALWAYS,
    RX_PATTERN,
    RX_RANDOM
  } rx_mode_t;

  typedef struct packed {
    logic signed [deq_pkg::DATA_W-1:0] data;
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic                              last;
  } deq_result_t;

  logic clk;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_core #(
    .DEPTH (DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the deque contents
  logic signed [deq_pkg::DATA_W-1:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]                  head_pos;
  logic [IDX_W:0]                    fill_cnt;

  deq_result_t expected_results [$];
  deq_result_t want_res;
  int          mismatch_cnt;
  int          quiet_cycles;

  // sender and receiver pacing
  bit          gaps_on;
  int          burst_left;
  rx_mode_t    rx_mode;
  logic [7:0]  stall_pat;
  int          rx_phase;
  int          hold_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // deque predictor
  // ---------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] ring_slot(input int offset);
    return IDX_W'((int'(head_pos) + offset) % DEPTH);
  endfunction

  function automatic void expect_result(input logic signed [deq_pkg::DATA_W-1:0] data,
                                        input deq_pkg::status_t status, input logic last);
    deq_result_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_deque_op(input logic [deq_pkg::OP_W-1:0] op,
                                           input logic signed [deq_pkg::DATA_W-1:0] val);
    case (op)
      deq_pkg::OP_LIST: begin
        if (fill_cnt == 0) begin
          expect_result('0, deq_pkg::ST_UNDERFLOW, 1'b1);
        end else begin
          for (int i = 0; i < int'(fill_cnt); i++) begin
            expect_result(ring_mem[ring_slot(i)], deq_pkg::ST_OK, i == int'(fill_cnt) - 1);
          end
        end
      end
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (fill_cnt == DEPTH) begin
          expect_result('0, deq_pkg::ST_OVERFLOW, 1'b1);
        end else begin
          if (op == deq_pkg::OP_PUSH_FRONT) begin
            head_pos           = ring_slot(DEPTH - 1);
            ring_mem[head_pos] = val;
          end else begin
            ring_mem[ring_slot(int'(fill_cnt))] = val;
          end
          fill_cnt = fill_cnt + (IDX_W + 1)'(1);
          expect_result('0, deq_pkg::ST_OK, 1'b1);
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (fill_cnt == 0) begin
          expect_result('0, deq_pkg::ST_UNDERFLOW, 1'b1);
        end else begin
          if (op == deq_pkg::OP_POP_FRONT) begin
            expect_result(ring_mem[head_pos], deq_pkg::ST_OK, 1'b1);
            head_pos = ring_slot(1);
          end else begin
            expect_result(ring_mem[ring_slot(int'(fill_cnt) - 1)], deq_pkg::ST_OK, 1'b1);
          end
          fill_cnt = fill_cnt - (IDX_W + 1)'(1);
        end
      end
      default: ;  // unused codes leave the deque untouched
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [deq_pkg::DATA_W-1:0] want,
                                 input logic [deq_pkg::DATA_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // items are predicted before results are checked, all from pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        predict_deque_op(in_ch.operation, in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending", '0, out_ch.data);
        end else begin
          want_res = expected_results.pop_front();
          if (out_ch.data !== want_res.data)
            report_mismatch("data", want_res.data, out_ch.data);
          if (out_ch.status !== want_res.status)
            report_mismatch("status", 32'(want_res.status), 32'(out_ch.status));
          if (out_ch.last !== want_res.last)
            report_mismatch("last", 32'(want_res.last), 32'(out_ch.last));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: long hold first, otherwise the current stall mode
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_PATTERN: begin
          out_ch.ready <= stall_pat[rx_phase % 8];
          rx_phase++;
          if (rx_phase % 64 == 0)
            stall_pat = 8'($urandom_range(1, 255));
        end
        default: out_ch.ready <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [deq_pkg::OP_W-1:0] op,
                           input logic signed [deq_pkg::DATA_W-1:0] val);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap        = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  task automatic set_traffic(input bit gaps, input rx_mode_t mode);
    gaps_on    = gaps;
    burst_left = 0;
    rx_mode    = mode;
  endtask

  function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // push_pct steers the fill level: high values reach full, low values empty
  function automatic logic [deq_pkg::OP_W-1:0] pick_op(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      return deq_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    if (r < 13)
      return deq_pkg::OP_LIST;
    if (r < 13 + push_pct)
      return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
    return $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
  endfunction

  // dropped codes do not count toward the item total
  task automatic run_random(input int count, input int push_pct);
    logic [deq_pkg::OP_W-1:0] op;
    int                       n;
    n = 0;
    while (n < count) begin
      op = pick_op(push_pct);
      send_item(op, pick_value());
      if (op <= deq_pkg::OP_POP_BACK)
        n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_queue();
    send_item(deq_pkg::OP_LIST, $urandom);
    send_item(deq_pkg::OP_POP_FRONT, $urandom);
    send_item(deq_pkg::OP_POP_BACK, $urandom);
    send_item(OP_UNUSED_LAST, $urandom);
  endtask

  // one entry is both front and back; popping it empties the queue
  task automatic test_single_entry();
    send_item(deq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    send_item(deq_pkg::OP_POP_BACK, $urandom);
    send_item(deq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
    send_item(deq_pkg::OP_LIST, $urandom);
    send_item(deq_pkg::OP_POP_FRONT, $urandom);
  endtask

  task automatic test_fill_and_overflow();
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       send_item(deq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
        1:       send_item(deq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        2:       send_item(deq_pkg::OP_PUSH_BACK, -32'sd1);
        default: send_item(deq_pkg::OP_PUSH_FRONT, $urandom);
      endcase
    end
    send_item(deq_pkg::OP_PUSH_FRONT, $urandom);
    send_item(deq_pkg::OP_PUSH_BACK, $urandom);
    send_item(deq_pkg::OP_LIST, $urandom);
  endtask

  task automatic test_random_fill_heavy();
    set_traffic(1'b1, RX_PATTERN);
    run_random(80, 65);
  endtask

  task automatic test_random_drain_heavy();
    set_traffic(1'b1, RX_RANDOM);
    run_random(80, 25);
  endtask

  task automatic test_random_back_to_back();
    set_traffic(1'b0, RX_ALWAYS);
    run_random(80, 45);
  endtask

  task automatic test_random_mixed();
    set_traffic(1'b1, RX_RANDOM);
    run_random(80, 50);
  endtask

  // receiver holds off while the sender keeps offering, so input backs up
  task automatic test_output_backpressure();
    set_traffic(1'b0, RX_ALWAYS);
    hold_cycles = LONG_HOLD;
    run_random(24, 60);
  endtask

  task automatic test_drain_pause();
    set_traffic(1'b1, RX_PATTERN);
    run_random(20, 50);
    wait_drained();
    run_random(20, 50);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = deq_pkg::OP_LIST;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    head_pos        = '0;
    fill_cnt        = '0;
    mismatch_cnt    = 0;
    quiet_cycles    = 0;
    hold_cycles     = 0;
    rx_phase        = 0;
    stall_pat       = 8'($urandom_range(1, 255));
    set_traffic(1'b0, RX_ALWAYS);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_queue();
    test_single_entry();
    test_fill_and_overflow();
    test_random_fill_heavy();
    test_random_drain_heavy();
    test_output_backpressure();
    test_random_back_to_back();
    test_drain_pause();
    test_random_mixed();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
